### rtl/level_threshold_map_smooth_core_defines.svh
// Assertion macros for the level map and smoother checker.
`ifndef LEVEL_THRESHOLD_MAP_SMOOTH_CORE_DEFINES_SVH
`define LEVEL_THRESHOLD_MAP_SMOOTH_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LTMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ltms assertion failed");

// Check that cons holds in the cycle after ante.
`define LTMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ltms assertion failed");

`endif

### rtl/ltms_pkg.sv
// Shared types and constants of the level map and smoother.
package ltms_pkg;

	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// 1.0 in unsigned Q1.16, 0.5 in Q20.16
	localparam logic [16:0] ONE_Q16  = 17'h10000;
	localparam logic [35:0] HALF_Q16 = 36'h000008000;

	typedef enum logic [2:0] {
		REG_ENABLE         = 3'd0,
		REG_LEVEL_THRESH   = 3'd1,
		REG_GAIN           = 3'd2,
		REG_INVERT_SIGNAL  = 3'd3,
		REG_BASE_LEVEL     = 3'd4,
		REG_MAX_LEVEL      = 3'd5,
		REG_SMOOTHING_RATE = 3'd6
	} cfg_reg_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [15:0] num;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quo;
	} div_rsp_t;

endpackage

### rtl/ltms_if.sv
// Channel interfaces: input samples, results and configuration writes.
interface ltms_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] vu_level;
	logic [15:0] frame_time;

	modport source (output valid, output vu_level, output frame_time, input ready);
	modport sink (input valid, input vu_level, input frame_time, output ready);
endinterface

interface ltms_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] smoothed_value;

	modport source (output valid, output smoothed_value, input ready);
	modport sink (input valid, input smoothed_value, output ready);
endinterface

interface ltms_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ltms_div.sv
// Restoring divider, one quotient bit per cycle, for the level rescale.
module ltms_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ltms_pkg::div_req_t req,
	output ltms_pkg::div_rsp_t rsp
);
	import ltms_pkg::*;

	logic [16:0]          rem_q;
	logic [15:0]          quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [17:0]          shifted;
	logic                 ge;

	// shift in a zero and try the subtract
	assign shifted = {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: load numerator, then one step a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 17'(shifted - {1'b0, req.den}) : shifted[16:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### rtl/level_threshold_map_smooth_core.sv
// Top level: VU level threshold, gain, map and one-pole smoother.
//
// Usage:
//   samples carries one beat per meter update: vu_level (Q0.16) and
//   frame_time (Q0.16 seconds). results carries smoothed_value (Q8.8).
//   cfg writes one register per beat (index 0..6); it is always ready and
//   must be used only while no sample is in flight.
// Timing:
//   An accepted sample runs a 16-step restoring divider for the level
//   rescale, after its load, then eight steps that make four passes
//   through one shared 18x18 multiplier, then returns to idle. A new
//   sample is taken only in idle, once the last one has written its
//   result; samples.ready is low while a sample is being worked on.
//   With enable at 0 a sample is accepted and dropped; the block stays idle.
// Reset:
//   arst_n clears the smoothed value to zero and loads the register
//   defaults (enabled, unity gain, map 0..1.0, rate 10.0).
// Stall:
//   The result waits in an output register; the block may accept and work
//   on the next sample meanwhile and holds before writing its result.
module level_threshold_map_smooth_core (
	input  logic        clk,
	input  logic        arst_n,
	ltms_in_if.sink     samples,
	ltms_out_if.source  results,
	ltms_cfg_if.sink    cfg
);
	import ltms_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_GAIN_MUL,
		ST_GAIN_SAT,
		ST_FAC_SAT,
		ST_MAP_MUL,
		ST_MAP_ADD,
		ST_SMO_LD,
		ST_SMO_MUL,
		ST_SMO_ADD
	} state_t;

	state_t state_q;

	// configuration registers
	logic               enable_q;
	logic [15:0]        thresh_q;
	logic [15:0]        gain_q;
	logic               invert_q;
	logic signed [15:0] base_q;
	logic signed [15:0] max_q;
	logic [15:0]        rate_q;

	// working registers
	logic signed [15:0] cur_q;
	logic [15:0]        ftime_q;
	logic               above_q;
	logic signed [17:0] mul_a_q;
	logic signed [17:0] mul_b_q;
	logic signed [35:0] prod_q;
	logic [16:0]        sig_q;
	logic [16:0]        fac_q;
	logic signed [15:0] target_q;
	logic               out_valid_q;
	logic signed [15:0] out_data_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               accept;
	logic               out_free;
	logic signed [35:0] mul_p;
	logic [16:0]        scaled_sat;
	logic [16:0]        sig_next;
	logic signed [35:0] prod_round;
	logic signed [19:0] round_q16;
	logic signed [19:0] map_sum;
	logic signed [19:0] smo_sum;
	logic signed [16:0] span;
	logic signed [16:0] err;

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || results.ready;
	assign cfg.ready     = 1'b1;

	// launch the rescale divide on an enabled beat
	assign div_req.start = accept && enable_q;
	assign div_req.num   = samples.vu_level - thresh_q;
	assign div_req.den   = ONE_Q16 - {1'b0, thresh_q};

	ltms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// shared multiplier
	assign mul_p = mul_a_q * mul_b_q;

	// drop 8 fraction bits and saturate at 1.0
	assign scaled_sat = (prod_q[31:8] > {7'd0, ONE_Q16}) ? ONE_Q16 : prod_q[24:8];
	assign sig_next   = invert_q ? 17'(ONE_Q16 - scaled_sat) : scaled_sat;

	// round half up and floor by 2^16
	assign prod_round = prod_q + $signed(HALF_Q16);
	assign round_q16  = prod_round[35:16];
	assign map_sum    = 20'(base_q) + round_q16;
	assign smo_sum    = 20'(cur_q) + round_q16;

	assign span = 17'(max_q) - 17'(base_q);
	assign err  = 17'(target_q) - 17'(cur_q);

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			thresh_q <= 16'd0;
			gain_q   <= 16'd256;
			invert_q <= 1'b0;
			base_q   <= 16'sd0;
			max_q    <= 16'sd256;
			rate_q   <= 16'd2560;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ENABLE:         enable_q <= cfg.data[0];
				REG_LEVEL_THRESH:   thresh_q <= cfg.data;
				REG_GAIN:           gain_q   <= cfg.data;
				REG_INVERT_SIGNAL:  invert_q <= cfg.data[0];
				REG_BASE_LEVEL:     base_q   <= $signed(cfg.data);
				REG_MAX_LEVEL:      max_q    <= $signed(cfg.data);
				REG_SMOOTHING_RATE: rate_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer with smoothed value and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= 16'sd0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the result beat on write, drop it once taken
			if (state_q == ST_SMO_ADD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && enable_q) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_GAIN_MUL;
					end
				end
				ST_GAIN_MUL: state_q <= ST_GAIN_SAT;
				ST_GAIN_SAT: state_q <= ST_FAC_SAT;
				ST_FAC_SAT:  state_q <= ST_MAP_MUL;
				ST_MAP_MUL:  state_q <= ST_MAP_ADD;
				ST_MAP_ADD:  state_q <= ST_SMO_LD;
				ST_SMO_LD:   state_q <= ST_SMO_MUL;
				ST_SMO_MUL:  state_q <= ST_SMO_ADD;
				ST_SMO_ADD: begin
					if (out_free) begin
						cur_q   <= smo_sum[15:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: operand loads and products per step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ftime_q <= samples.frame_time;
					above_q <= samples.vu_level > thresh_q;
				end
			end
			ST_DIV: begin
				mul_a_q <= {2'b00, (above_q ? div_rsp.quo : 16'd0)};
				mul_b_q <= {2'b00, gain_q};
			end
			ST_GAIN_MUL: begin
				prod_q  <= mul_p;
				mul_a_q <= {2'b00, rate_q};
				mul_b_q <= {2'b00, ftime_q};
			end
			ST_GAIN_SAT: begin
				sig_q  <= sig_next;
				prod_q <= mul_p;
			end
			ST_FAC_SAT: begin
				fac_q   <= scaled_sat;
				mul_a_q <= 18'(span);
				mul_b_q <= {1'b0, sig_q};
			end
			ST_MAP_MUL: prod_q <= mul_p;
			ST_MAP_ADD: target_q <= map_sum[15:0];
			ST_SMO_LD: begin
				mul_a_q <= 18'(err);
				mul_b_q <= {1'b0, fac_q};
			end
			ST_SMO_MUL: prod_q <= mul_p;
			ST_SMO_ADD: begin
				if (out_free) begin
					out_data_q <= smo_sum[15:0];
				end
			end
			default: ;
		endcase
	end

	assign results.valid          = out_valid_q;
	assign results.smoothed_value = out_data_q;

endmodule

### rtl/ltms_checker.sv
// Port-level checker for the level map and smoother, bound to the top level.
`include "level_threshold_map_smooth_core_defines.svh"

module ltms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_data,
	input logic        cfg_ready
);

	// result beat holds while stalled
	`LTMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`LTMS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))

	// a new result appears only while a sample was being worked on
	`LTMS_ASSERT_SAME(a_out_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

	// input side goes busy only after an offered sample
	`LTMS_ASSERT_SAME(a_busy_after_beat, clk, arst_n, $fell(in_ready), $past(in_valid))

	// configuration writes are never refused
	`LTMS_ASSERT_SAME(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)

endmodule

bind level_threshold_map_smooth_core ltms_checker u_ltms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.smoothed_value),
	.cfg_ready (cfg.ready)
);

### test/tb.sv
// Self-checking testbench for the level threshold, map and smoothing core.
module tb;
	import ltms_pkg::*;

	localparam int IDLE_PCT = 27;
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 105;
	localparam longint UNITY = 65536;
	localparam longint HALF = 32768;
	// no register lives at this index
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [15:0] vu_level;
		logic [15:0] frame_time;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n;

	ltms_in_if  sample_bus();
	ltms_out_if result_bus();
	ltms_cfg_if cfg_bus();

	level_threshold_map_smooth_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_bus),
		.results (result_bus),
		.cfg     (cfg_bus)
	);

	// register copies and the smoothed value the core should hold
	logic               cfg_enable;
	logic [15:0]        cfg_threshold;
	logic [15:0]        cfg_gain;
	logic               cfg_invert;
	logic signed [15:0] cfg_base;
	logic signed [15:0] cfg_max;
	logic [15:0]        cfg_rate;
	logic signed [15:0] held_value;

	sample_t            pending_samples[$];
	logic signed [15:0] pending_values[$];
	int                 mismatches = 0;
	logic               steady_flow = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Threshold, gain, map and smooth one beat; advance the held value.
	function automatic logic signed [15:0] advance_smoother(logic [15:0] level,
			logic [15:0] ftime);
		longint signal;
		longint factor;
		longint target;
		signal = 0;
		if (level > cfg_threshold)
			signal = ((longint'(level) - longint'(cfg_threshold)) <<< 16) /
				(UNITY - longint'(cfg_threshold));
		signal = (signal * longint'(cfg_gain)) >>> 8;
		if (signal > UNITY)
			signal = UNITY;
		if (cfg_invert)
			signal = UNITY - signal;
		target = longint'(cfg_base) +
			(((longint'(cfg_max) - longint'(cfg_base)) * signal + HALF) >>> 16);
		factor = (longint'(cfg_rate) * longint'(ftime)) >>> 8;
		if (factor > UNITY)
			factor = UNITY;
		held_value = 16'(longint'(held_value) +
			(((target - longint'(held_value)) * factor + HALF) >>> 16));
		return held_value;
	endfunction

	// Present queued samples, idling at random; predict each enabled beat.
	always @(posedge clk) begin : drive_samples
		logic fired;
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
		end else begin
			fired = sample_bus.valid && sample_bus.ready;
			if (fired) begin
				if (cfg_enable)
					pending_values.push_back(advance_smoother(sample_bus.vu_level,
						sample_bus.frame_time));
				void'(pending_samples.pop_front());
			end
			if (fired || !sample_bus.valid) begin
				if (pending_samples.size() != 0 &&
						(steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
					sample_bus.valid      <= 1'b1;
					sample_bus.vu_level   <= pending_samples[0].vu_level;
					sample_bus.frame_time <= pending_samples[0].frame_time;
				end else begin
					sample_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Compare each result beat with the oldest prediction; stall at random.
	always @(posedge clk) begin : watch_results
		logic signed [15:0] want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (pending_values.size() == 0) begin
					$error("smoothed_value: expected none, got %0d",
						result_bus.smoothed_value);
					mismatches++;
				end else begin
					want = pending_values.pop_front();
					if (result_bus.smoothed_value !== want) begin
						$error("smoothed_value: expected %0d, got %0d", want,
							result_bus.smoothed_value);
						mismatches++;
					end
				end
			end
			result_bus.ready <= steady_flow || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Write one register and mirror it once the beat is taken.
	task automatic set_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_ENABLE:         cfg_enable    = val[0];
			REG_LEVEL_THRESH:   cfg_threshold = val;
			REG_GAIN:           cfg_gain      = val;
			REG_INVERT_SIGNAL:  cfg_invert    = val[0];
			REG_BASE_LEVEL:     cfg_base      = val;
			REG_MAX_LEVEL:      cfg_max       = val;
			REG_SMOOTHING_RATE: cfg_rate      = val;
			default: ;
		endcase
	endtask

	task automatic add_sample(logic [15:0] level, logic [15:0] ftime);
		pending_samples.push_back('{vu_level: level, frame_time: ftime});
	endtask

	// Wait until every queued beat went in and every result came out, then
	// let the pipeline run dry before any register write.
	task automatic settle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || sample_bus.valid || pending_values.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_level();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h0100;
			default: return 16'($urandom());
		endcase
	endfunction

	// Draw a fresh setting, extremes included.
	task automatic shuffle_settings();
		case ($urandom_range(3))
			0: set_reg(REG_LEVEL_THRESH, 16'd0);
			1: set_reg(REG_LEVEL_THRESH, 16'd65534);
			2: set_reg(REG_LEVEL_THRESH, 16'($urandom_range(16384)));
			default: set_reg(REG_LEVEL_THRESH, 16'($urandom_range(65534)));
		endcase
		case ($urandom_range(4))
			0: set_reg(REG_GAIN, 16'd0);
			1: set_reg(REG_GAIN, 16'hFFFF);
			2, 3: set_reg(REG_GAIN, 16'($urandom_range(1024, 64)));
			default: set_reg(REG_GAIN, 16'($urandom()));
		endcase
		set_reg(REG_INVERT_SIGNAL, 16'($urandom_range(1)));
		set_reg(REG_BASE_LEVEL, pick_level());
		set_reg(REG_MAX_LEVEL, pick_level());
		case ($urandom_range(4))
			0: set_reg(REG_SMOOTHING_RATE, 16'd0);
			1: set_reg(REG_SMOOTHING_RATE, 16'hFFFF);
			2, 3: set_reg(REG_SMOOTHING_RATE, 16'($urandom_range(8000)));
			default: set_reg(REG_SMOOTHING_RATE, 16'($urandom()));
		endcase
		set_reg(REG_ENABLE, 16'd1);
	endtask

	// Queue random beats, many of them just around the threshold.
	task automatic add_random_samples(int count);
		int near;
		logic [15:0] level;
		logic [15:0] ftime;
		repeat (count) begin
			case ($urandom_range(9))
				0: level = 16'd0;
				1: level = 16'hFFFF;
				2, 3, 4: begin
					near = int'(cfg_threshold) + int'($urandom_range(64)) - 32;
					level = near < 0 ? 16'd0 : near > 65535 ? 16'hFFFF : 16'(near);
				end
				default: level = 16'($urandom());
			endcase
			case ($urandom_range(7))
				0: ftime = 16'd0;
				1: ftime = 16'hFFFF;
				2, 3, 4, 5: ftime = 16'($urandom_range(1500));
				default: ftime = 16'($urandom());
			endcase
			add_sample(level, ftime);
		end
	endtask

	// Reset, directed cases, then random phases under changing settings.
	initial begin
		arst_n = 1'b0;
		sample_bus.valid = 1'b0;
		sample_bus.vu_level = '0;
		sample_bus.frame_time = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		cfg_enable = 1'b1;
		cfg_threshold = 16'd0;
		cfg_gain = 16'd256;
		cfg_invert = 1'b0;
		cfg_base = 16'sd0;
		cfg_max = 16'sd256;
		cfg_rate = 16'd2560;
		held_value = 16'sd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, one beat at a time with the pipeline drained
		add_sample(16'd0, 16'd0);
		settle();
		add_sample(16'hFFFF, 16'hFFFF);
		settle();
		add_sample(16'hFFFF, 16'd0);
		settle();
		add_sample(16'd32768, 16'd3277);
		settle();
		add_sample(16'd0, 16'hFFFF);
		settle();

		// full threshold: no level can exceed it
		set_reg(REG_LEVEL_THRESH, 16'hFFFF);
		add_sample(16'hFFFF, 16'hFFFF);
		settle();

		// highest legal threshold with the largest gain saturates the signal
		set_reg(REG_LEVEL_THRESH, 16'd65534);
		set_reg(REG_GAIN, 16'hFFFF);
		add_sample(16'hFFFF, 16'hFFFF);
		add_sample(16'd65534, 16'hFFFF);
		settle();

		set_reg(REG_GAIN, 16'd0);
		add_sample(16'hFFFF, 16'hFFFF);
		settle();

		set_reg(REG_LEVEL_THRESH, 16'd0);
		set_reg(REG_GAIN, 16'd256);
		set_reg(REG_INVERT_SIGNAL, 16'd1);
		add_sample(16'd0, 16'hFFFF);
		add_sample(16'hFFFF, 16'hFFFF);
		settle();

		// widest map, both directions
		set_reg(REG_INVERT_SIGNAL, 16'd0);
		set_reg(REG_BASE_LEVEL, 16'h8000);
		set_reg(REG_MAX_LEVEL, 16'h7FFF);
		add_sample(16'hFFFF, 16'hFFFF);
		add_sample(16'd0, 16'hFFFF);
		settle();
		set_reg(REG_BASE_LEVEL, 16'h7FFF);
		set_reg(REG_MAX_LEVEL, 16'h8000);
		add_sample(16'hFFFF, 16'hFFFF);
		add_sample(16'd0, 16'd100);
		settle();

		// zero rate holds the value; the largest rate jumps at once
		set_reg(REG_SMOOTHING_RATE, 16'd0);
		add_sample(16'hFFFF, 16'hFFFF);
		settle();
		set_reg(REG_SMOOTHING_RATE, 16'hFFFF);
		add_sample(16'd40000, 16'd1);
		add_sample(16'hFFFF, 16'hFFFF);
		settle();

		// disabled: beats are dropped and the value is kept
		set_reg(REG_ENABLE, 16'd0);
		add_sample(16'hFFFF, 16'hFFFF);
		add_sample(16'd0, 16'd0);
		settle();

		// a write to an unused index must change nothing
		set_reg(REG_UNUSED, 16'hFFFF);
		set_reg(REG_ENABLE, 16'd1);
		add_sample(16'd30000, 16'd30000);
		settle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			shuffle_settings();
			steady_flow = (phase == 2);
			add_random_samples(PHASE_SAMPLES);
			settle();
			steady_flow = 1'b0;
			// one short disabled stretch in the middle of the run
			if (phase == 4) begin
				set_reg(REG_ENABLE, 16'd0);
				add_random_samples(20);
				settle();
			end
		end

		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#4000000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

### level_threshold_map_smooth_core.f
+incdir+rtl
rtl/ltms_pkg.sv
rtl/ltms_if.sv
rtl/ltms_div.sv
rtl/level_threshold_map_smooth_core.sv
rtl/ltms_checker.sv
test/tb.sv
